FILE: design/lkdd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lock deadlock detector package
// Shared types, status codes and default sizes for the lock manager.
// ---------------------------------------------------------------------------
package lkdd_pkg;

    localparam int NUM_THREADS_DEF = 16;
    localparam int NUM_LOCKS_DEF   = 16;
    localparam int ID_W            = 4;
    localparam int STATUS_W        = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_WAITS    = 3'd1,
        ST_DEADLOCK = 3'd2,
        ST_FREED    = 3'd3,
        ST_HANDOVER = 3'd4,
        ST_NOT_HELD = 3'd5,
        ST_HALTED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OWN,
        S_LINK,
        S_REL,
        S_SCAN
    } ctrl_state_t;

    // Table access strobes from the sequencer to the table store.
    typedef struct packed {
        logic own_rd;
        logic own_wr;
        logic held_wr;
        logic held_val;
        logic wait_rd;
        logic wait_wr;
        logic waits_wr;
        logic waits_val;
    } tbl_ctl_t;

    typedef struct packed {
        logic            done;
        status_t         status;
        logic [ID_W-1:0] new_owner;
    } result_t;

endpackage

FILE: design/lkdd_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lock deadlock detector table store
// Owner memory per lock, awaited-lock memory per thread, and their valid bits.
// ---------------------------------------------------------------------------
module lkdd_store #(
    parameter int NUM_THREADS = lkdd_pkg::NUM_THREADS_DEF,
    parameter int NUM_LOCKS   = lkdd_pkg::NUM_LOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkdd_pkg::tbl_ctl_t             ctl,
    input  logic [$clog2(NUM_LOCKS)-1:0]   own_addr,
    input  logic [$clog2(NUM_THREADS)-1:0] own_wdata,
    output logic [$clog2(NUM_THREADS)-1:0] own_rdata,
    input  logic [$clog2(NUM_THREADS)-1:0] wait_addr,
    input  logic [$clog2(NUM_LOCKS)-1:0]   wait_wdata,
    output logic [$clog2(NUM_LOCKS)-1:0]   wait_rdata,
    input  logic [$clog2(NUM_LOCKS)-1:0]   held_qaddr,
    output logic                           held_q,
    input  logic [$clog2(NUM_THREADS)-1:0] waits_qaddr,
    output logic                           waits_q
);
    import lkdd_pkg::*;

    localparam int TW = $clog2(NUM_THREADS);
    localparam int LW = $clog2(NUM_LOCKS);

    logic [TW-1:0]          own_mem  [NUM_LOCKS];
    logic [LW-1:0]          wait_mem [NUM_THREADS];
    logic [NUM_LOCKS-1:0]   held_reg;
    logic [NUM_THREADS-1:0] waits_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.own_wr)
        begin
            own_mem[own_addr] <= own_wdata;
        end
        if (ctl.own_rd)
        begin
            own_rdata <= own_mem[own_addr];
        end
        if (ctl.wait_wr)
        begin
            wait_mem[wait_addr] <= wait_wdata;
        end
        if (ctl.wait_rd)
        begin
            wait_rdata <= wait_mem[wait_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            waits_reg <= '0;
        end
        else
        begin
            if (ctl.held_wr)
            begin
                held_reg[own_addr] <= ctl.held_val;
            end
            if (ctl.waits_wr)
            begin
                waits_reg[wait_addr] <= ctl.waits_val;
            end
        end
    end

    assign held_q  = held_reg[held_qaddr];
    assign waits_q = waits_reg[waits_qaddr];

endmodule

FILE: design/lkdd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lock deadlock detector sequencer
// Walks the wait chain, scans the wait table and updates the tables.
// ---------------------------------------------------------------------------
module lkdd_ctrl #(
    parameter int NUM_THREADS = lkdd_pkg::NUM_THREADS_DEF,
    parameter int NUM_LOCKS   = lkdd_pkg::NUM_LOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           kind,
    input  logic [lkdd_pkg::ID_W-1:0]      thread_id,
    input  logic [lkdd_pkg::ID_W-1:0]      lock_id,
    output lkdd_pkg::tbl_ctl_t             ctl,
    output logic [$clog2(NUM_LOCKS)-1:0]   own_addr,
    output logic [$clog2(NUM_THREADS)-1:0] own_wdata,
    input  logic [$clog2(NUM_THREADS)-1:0] own_rdata,
    output logic [$clog2(NUM_THREADS)-1:0] wait_addr,
    output logic [$clog2(NUM_LOCKS)-1:0]   wait_wdata,
    input  logic [$clog2(NUM_LOCKS)-1:0]   wait_rdata,
    output logic [$clog2(NUM_LOCKS)-1:0]   held_qaddr,
    input  logic                           held_q,
    output logic [$clog2(NUM_THREADS)-1:0] waits_qaddr,
    input  logic                           waits_q,
    output lkdd_pkg::result_t              result
);
    import lkdd_pkg::*;

    localparam int TW = $clog2(NUM_THREADS);
    localparam int LW = $clog2(NUM_LOCKS);
    localparam int SW = $clog2(NUM_THREADS + 1);

    ctrl_state_t   state_reg, state_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [TW-1:0] scan_reg, scan_next;
    logic          halted_reg, halted_next;

    logic [TW-1:0] tid_w;
    logic [LW-1:0] lock_w;
    logic          in_range;
    logic [SW-1:0] steps_inc;

    assign tid_w     = TW'(thread_id);
    assign lock_w    = LW'(lock_id);
    assign in_range  = (32'(thread_id) < NUM_THREADS) && (32'(lock_id) < NUM_LOCKS);
    assign steps_inc = steps_reg + SW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            steps_reg  <= '0;
            scan_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            steps_reg  <= steps_next;
            scan_reg   <= scan_next;
            halted_reg <= halted_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        steps_next       = steps_reg;
        scan_next        = scan_reg;
        halted_next      = halted_reg;
        ctl              = '0;
        own_addr         = lock_w;
        own_wdata        = tid_w;
        wait_addr        = tid_w;
        wait_wdata       = lock_w;
        held_qaddr       = lock_w;
        waits_qaddr      = own_rdata;
        result.done      = 1'b0;
        result.status    = ST_GRANTED;
        result.new_owner = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (halted_reg)
                    begin
                        result.done   = 1'b1;
                        result.status = ST_HALTED;
                    end
                    else if (!in_range)
                    begin
                        result.done   = 1'b1;
                        result.status = ST_NOT_HELD;
                    end
                    else if (kind)
                    begin
                        if (!held_q)
                        begin
                            ctl.own_wr    = 1'b1;
                            ctl.held_wr   = 1'b1;
                            ctl.held_val  = 1'b1;
                            result.done   = 1'b1;
                            result.status = ST_GRANTED;
                        end
                        else
                        begin
                            ctl.own_rd = 1'b1;
                            steps_next = '0;
                            state_next = S_OWN;
                        end
                    end
                    else if (!held_q)
                    begin
                        result.done   = 1'b1;
                        result.status = ST_NOT_HELD;
                    end
                    else
                    begin
                        ctl.own_rd = 1'b1;
                        state_next = S_REL;
                    end
                end
            end

            // Owner of the current chain lock is on the read port.
            S_OWN:
            begin
                waits_qaddr = own_rdata;
                if (own_rdata == tid_w)
                begin
                    halted_next   = 1'b1;
                    result.done   = 1'b1;
                    result.status = ST_DEADLOCK;
                    state_next    = S_IDLE;
                end
                else if (!waits_q)
                begin
                    ctl.wait_wr   = 1'b1;
                    ctl.waits_wr  = 1'b1;
                    ctl.waits_val = 1'b1;
                    result.done   = 1'b1;
                    result.status = ST_WAITS;
                    state_next    = S_IDLE;
                end
                else
                begin
                    wait_addr   = own_rdata;
                    ctl.wait_rd = 1'b1;
                    state_next  = S_LINK;
                end
            end

            // The lock awaited by that owner is on the read port.
            S_LINK:
            begin
                held_qaddr = wait_rdata;
                steps_next = steps_inc;
                if (steps_inc == SW'(NUM_THREADS) || !held_q)
                begin
                    ctl.wait_wr   = 1'b1;
                    ctl.waits_wr  = 1'b1;
                    ctl.waits_val = 1'b1;
                    result.done   = 1'b1;
                    result.status = ST_WAITS;
                    state_next    = S_IDLE;
                end
                else
                begin
                    own_addr   = wait_rdata;
                    ctl.own_rd = 1'b1;
                    state_next = S_OWN;
                end
            end

            S_REL:
            begin
                if (own_rdata != tid_w)
                begin
                    result.done   = 1'b1;
                    result.status = ST_NOT_HELD;
                    state_next    = S_IDLE;
                end
                else
                begin
                    scan_next   = '0;
                    wait_addr   = '0;
                    ctl.wait_rd = 1'b1;
                    state_next  = S_SCAN;
                end
            end

            // Wait entry of scan_reg is on the read port; lowest waiter wins.
            S_SCAN:
            begin
                waits_qaddr = scan_reg;
                if (waits_q && wait_rdata == lock_w)
                begin
                    ctl.own_wr       = 1'b1;
                    own_wdata        = scan_reg;
                    wait_addr        = scan_reg;
                    ctl.waits_wr     = 1'b1;
                    ctl.waits_val    = 1'b0;
                    result.done      = 1'b1;
                    result.status    = ST_HANDOVER;
                    result.new_owner = ID_W'(scan_reg);
                    state_next       = S_IDLE;
                end
                else if (scan_reg == TW'(NUM_THREADS - 1))
                begin
                    ctl.held_wr   = 1'b1;
                    ctl.held_val  = 1'b0;
                    result.done   = 1'b1;
                    result.status = ST_FREED;
                    state_next    = S_IDLE;
                end
                else
                begin
                    scan_next   = scan_reg + TW'(1);
                    wait_addr   = scan_reg + TW'(1);
                    ctl.wait_rd = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/lock_deadlock_detector_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lock deadlock detector
// Lock manager with wait-for-graph deadlock detection and sticky halt.
// ---------------------------------------------------------------------------
// One item is handled at a time; in_stall stays high from acceptance until
// its result item has been taken. The tables are single-port memories read
// one entry per cycle. An item that needs no table read finishes without
// one; an acquire of a held lock walks the chain from owner to awaited lock
// and ends at a deadlock, at an owner that waits on nothing, at a free lock
// or at the link limit; a valid release scans the wait table upward from
// thread 0 for the first waiter and frees the lock if it finds none. The
// next item is accepted only after the result has been taken.
module lock_deadlock_detector_unit #(
    parameter int NUM_THREADS = lkdd_pkg::NUM_THREADS_DEF,
    parameter int NUM_LOCKS   = lkdd_pkg::NUM_LOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [lkdd_pkg::ID_W-1:0]     thread_id,
    input  logic [lkdd_pkg::ID_W-1:0]     lock_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lkdd_pkg::STATUS_W-1:0] status,
    output logic [lkdd_pkg::ID_W-1:0]     new_owner
);
    import lkdd_pkg::*;

    localparam int TW = $clog2(NUM_THREADS);
    localparam int LW = $clog2(NUM_LOCKS);

    logic            busy_reg;
    logic            start_reg;
    logic            kind_reg;
    logic [ID_W-1:0] tid_reg;
    logic [ID_W-1:0] lock_reg;
    logic            out_valid_reg;
    status_t         status_reg;
    logic [ID_W-1:0] new_owner_reg;

    logic          in_acc;
    logic          out_acc;
    tbl_ctl_t      ctl;
    result_t       result;
    logic [LW-1:0] own_addr;
    logic [TW-1:0] own_wdata;
    logic [TW-1:0] own_rdata;
    logic [TW-1:0] wait_addr;
    logic [LW-1:0] wait_wdata;
    logic [LW-1:0] wait_rdata;
    logic [LW-1:0] held_qaddr;
    logic          held_q;
    logic [TW-1:0] waits_qaddr;
    logic          waits_q;

    assign in_acc  = in_valid && !busy_reg;
    assign out_acc = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= in_acc;
            if (in_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                busy_reg <= 1'b0;
            end
            if (result.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg <= kind;
            tid_reg  <= thread_id;
            lock_reg <= lock_id;
        end
        if (result.done)
        begin
            status_reg    <= result.status;
            new_owner_reg <= result.new_owner;
        end
    end

    lkdd_ctrl #(
        .NUM_THREADS (NUM_THREADS),
        .NUM_LOCKS   (NUM_LOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start_reg),
        .kind        (kind_reg),
        .thread_id   (tid_reg),
        .lock_id     (lock_reg),
        .ctl         (ctl),
        .own_addr    (own_addr),
        .own_wdata   (own_wdata),
        .own_rdata   (own_rdata),
        .wait_addr   (wait_addr),
        .wait_wdata  (wait_wdata),
        .wait_rdata  (wait_rdata),
        .held_qaddr  (held_qaddr),
        .held_q      (held_q),
        .waits_qaddr (waits_qaddr),
        .waits_q     (waits_q),
        .result      (result)
    );

    lkdd_store #(
        .NUM_THREADS (NUM_THREADS),
        .NUM_LOCKS   (NUM_LOCKS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .own_addr    (own_addr),
        .own_wdata   (own_wdata),
        .own_rdata   (own_rdata),
        .wait_addr   (wait_addr),
        .wait_wdata  (wait_wdata),
        .wait_rdata  (wait_rdata),
        .held_qaddr  (held_qaddr),
        .held_q      (held_q),
        .waits_qaddr (waits_qaddr),
        .waits_q     (waits_q)
    );

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign new_owner = new_owner_reg;

    // A result item can only be pending while the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result pending while block accepts items");

    // A finished item never overwrites a result that is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.done |-> !out_valid_reg)
        else $error("result produced while previous one pending");

    // Only a handover names a new owner.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_HANDOVER) |-> new_owner == '0)
        else $error("new_owner set on a result other than handover");

endmodule
